### rtl/spk_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spk_pkg: shared types, constants and rotate helpers
// Word size, round count and the per-stage transaction type of the Speck
// round pipeline.
// ----------------------------------------------------------------------------
package spk_pkg;

    localparam int WORD_BITS = 64;
    localparam int ROUNDS    = 32;
    localparam int FIELD_W   = 64;
    localparam int CNT_W     = $clog2(ROUNDS);
    localparam int IDX_W     = 2;

    localparam logic [IDX_W-1:0] REG_KEY_LOW  = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_KEY_HIGH = IDX_W'(1);

    localparam logic FUNC_ENC = 1'b0;
    localparam logic FUNC_DEC = 1'b1;

    typedef logic [WORD_BITS-1:0] t_word;
    typedef t_word [ROUNDS-1:0]   t_rkeys;

    typedef struct packed {
        logic  vld;
        logic  func;
        t_word x;
        t_word y;
    } t_stage;

    function automatic t_word ror8(input t_word v);
        return {v[7:0], v[WORD_BITS-1:8]};
    endfunction

    function automatic t_word rol8(input t_word v);
        return {v[WORD_BITS-9:0], v[WORD_BITS-1:WORD_BITS-8]};
    endfunction

    function automatic t_word ror3(input t_word v);
        return {v[2:0], v[WORD_BITS-1:3]};
    endfunction

    function automatic t_word rol3(input t_word v);
        return {v[WORD_BITS-4:0], v[WORD_BITS-1:WORD_BITS-3]};
    endfunction

endpackage
`default_nettype wire

### rtl/spk_key_sched.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spk_key_sched: key registers and round key expansion
// Holds the two key words and expands them into the round key bank, one
// schedule round per cycle, after reset and after every key write.
// ----------------------------------------------------------------------------
module spk_key_sched (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_we,
    input  wire [spk_pkg::IDX_W-1:0]     i_cfg_index,
    input  wire [spk_pkg::FIELD_W-1:0]   i_cfg_data,
    output spk_pkg::t_rkeys              o_rkeys,
    output logic                         o_busy
);

    spk_pkg::t_word                r_key_lo, r_key_hi;
    spk_pkg::t_word                n_key_lo, n_key_hi;
    spk_pkg::t_word                r_k, r_l;
    spk_pkg::t_word                n_k, n_l;
    logic [spk_pkg::CNT_W-1:0]     r_cnt;
    logic                          r_busy;
    spk_pkg::t_rkeys               r_rkeys;

    always_comb begin
        n_key_lo = r_key_lo;
        n_key_hi = r_key_hi;
        if (i_cfg_we && i_cfg_index == spk_pkg::REG_KEY_LOW) begin
            n_key_lo = spk_pkg::WORD_BITS'(i_cfg_data);
        end
        if (i_cfg_we && i_cfg_index == spk_pkg::REG_KEY_HIGH) begin
            n_key_hi = spk_pkg::WORD_BITS'(i_cfg_data);
        end
    end

    // one schedule round: same shape as a data round, round index as key
    always_comb begin
        n_l = (spk_pkg::ror8(r_l) + r_k) ^ spk_pkg::WORD_BITS'(r_cnt);
        n_k = spk_pkg::rol3(r_k) ^ n_l;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_lo <= '0;
            r_key_hi <= '0;
            r_k      <= '0;
            r_l      <= '0;
            r_cnt    <= '0;
            r_busy   <= 1'b1;
        end else if (i_cfg_we) begin
            // restart expansion from the updated key
            r_key_lo <= n_key_lo;
            r_key_hi <= n_key_hi;
            r_k      <= n_key_lo;
            r_l      <= n_key_hi;
            r_cnt    <= '0;
            r_busy   <= 1'b1;
        end else if (r_busy) begin
            r_k   <= n_k;
            r_l   <= n_l;
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == spk_pkg::CNT_W'(spk_pkg::ROUNDS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy && !i_cfg_we) begin
            r_rkeys[r_cnt] <= r_k;
        end
    end

    assign o_rkeys = r_rkeys;
    assign o_busy  = r_busy;

endmodule
`default_nettype wire

### rtl/spk_round_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spk_round_cell: one registered Speck round
// Applies a forward or inverse round, per transaction, and hands the block
// to the next cell.
// ----------------------------------------------------------------------------
module spk_round_cell (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_en,
    input  wire spk_pkg::t_stage  i_stage,
    input  wire spk_pkg::t_word   i_k_enc,
    input  wire spk_pkg::t_word   i_k_dec,
    output spk_pkg::t_stage       o_stage
);

    logic            r_vld;
    logic            r_func;
    spk_pkg::t_word  r_x, r_y;
    spk_pkg::t_word  n_x, n_y;

    always_comb begin
        if (i_stage.func == spk_pkg::FUNC_ENC) begin
            n_x = (spk_pkg::ror8(i_stage.x) + i_stage.y) ^ i_k_enc;
            n_y = spk_pkg::rol3(i_stage.y) ^ n_x;
        end else begin
            n_y = spk_pkg::ror3(i_stage.y ^ i_stage.x);
            n_x = spk_pkg::rol8((i_stage.x ^ i_k_dec) - n_y);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_stage.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_func <= i_stage.func;
            r_x    <= n_x;
            r_y    <= n_y;
        end
    end

    assign o_stage = '{vld: r_vld, func: r_func, x: r_x, y: r_y};

endmodule
`default_nettype wire

### rtl/speck_block_cipher.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// speck_block_cipher: pipelined Speck two-word-key block cipher
// A chain of ROUNDS round cells, each holding one block in flight, fed from a
// round key bank that is expanded from the two key registers.
// ----------------------------------------------------------------------------
//  channel   handshake             payload
//  input     i_valid / o_ready     i_func, i_block_low, i_block_high
//  output    o_valid / i_ready     o_result_low, o_result_high
//  config    i_cfg_we              i_cfg_index, i_cfg_data
//
// One block per cycle while no output stall or key expansion holds the input;
// each round cell registers the block once. After reset and after each key write
// the key expander fills the whole bank, one schedule round per cycle, with o_ready low.
// The chain advances as a whole; a stalled output holds every cell.
// ----------------------------------------------------------------------------
module speck_block_cipher (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_we,
    input  wire [spk_pkg::IDX_W-1:0]     i_cfg_index,
    input  wire [spk_pkg::FIELD_W-1:0]   i_cfg_data,
    input  wire                          i_valid,
    output logic                         o_ready,
    input  wire                          i_func,
    input  wire [spk_pkg::FIELD_W-1:0]   i_block_low,
    input  wire [spk_pkg::FIELD_W-1:0]   i_block_high,
    output logic                         o_valid,
    input  wire                          i_ready,
    output logic [spk_pkg::FIELD_W-1:0]  o_result_low,
    output logic [spk_pkg::FIELD_W-1:0]  o_result_high
);

    spk_pkg::t_rkeys  w_rkeys;
    logic             w_key_busy;
    logic             w_en;
    spk_pkg::t_stage  w_stage [spk_pkg::ROUNDS+1];

    spk_key_sched u_key_sched (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_rkeys     (w_rkeys),
        .o_busy      (w_key_busy)
    );

    assign w_en    = !o_valid || i_ready;
    assign o_ready = w_en && !w_key_busy;

    assign w_stage[0] = '{vld:  i_valid && o_ready,
                          func: i_func,
                          x:    spk_pkg::WORD_BITS'(i_block_high),
                          y:    spk_pkg::WORD_BITS'(i_block_low)};

    for (genvar g = 0; g < spk_pkg::ROUNDS; g++) begin : g_cell
        spk_round_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_stage (w_stage[g]),
            .i_k_enc (w_rkeys[g]),
            .i_k_dec (w_rkeys[spk_pkg::ROUNDS-1-g]),
            .o_stage (w_stage[g+1])
        );
    end

    assign o_valid       = w_stage[spk_pkg::ROUNDS].vld;
    assign o_result_low  = spk_pkg::FIELD_W'(w_stage[spk_pkg::ROUNDS].y);
    assign o_result_high = spk_pkg::FIELD_W'(w_stage[spk_pkg::ROUNDS].x);

    // key bank must be rebuilt before any block is taken
    a_busy_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> w_key_busy)
        else $error("key expansion not started after reset");

    a_busy_after_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> w_key_busy)
        else $error("key expansion not restarted after key write");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_key_busy |-> !(i_valid && o_ready))
        else $error("block accepted during key expansion");

endmodule
`default_nettype wire

### dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: speck_block_cipher stream test
// Streams encrypt and decrypt blocks through the round pipeline under several
// keys, predicts every output block in the bench and checks it in order.
// ----------------------------------------------------------------------------
module testbench;
    import spk_pkg::*;

    typedef logic [FIELD_W-1:0] field_t;

    typedef struct packed {
        logic   func;
        field_t lo;
        field_t hi;
    } block_req_t;

    typedef struct packed {
        field_t lo;
        field_t hi;
    } block_res_t;

    typedef enum int {IDLE_NONE, IDLE_FULL, IDLE_SOME} idle_mode_t;

    localparam logic [IDX_W-1:0] REG_SPARE = IDX_W'(2);
    localparam int IDLE_MAX    = 19;
    localparam int CYCLE_LIMIT = 400000;
    localparam int REPORT_MAX  = 40;
    localparam int PHASE_ITEMS = 135;

    // published Speck128/128 vector
    localparam field_t VEC_KEY_LO = 64'h0706050403020100;
    localparam field_t VEC_KEY_HI = 64'h0f0e0d0c0b0a0908;
    localparam field_t VEC_PT_LO  = 64'h7469206e69766c65;
    localparam field_t VEC_PT_HI  = 64'h6c61766975716520;
    localparam field_t VEC_CT_LO  = 64'h7860fedf5c570d18;
    localparam field_t VEC_CT_HI  = 64'ha65d985179783265;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             cfg_we    = 1'b0;
    logic [IDX_W-1:0] cfg_index = '0;
    field_t           cfg_data  = '0;
    logic             drv_valid = 1'b0;
    logic             drv_func  = 1'b0;
    field_t           drv_lo    = '0;
    field_t           drv_hi    = '0;
    logic             rcv_ready = 1'b0;
    logic             dut_ready;
    logic             dut_valid;
    field_t           res_lo;
    field_t           res_hi;

    field_t       key_lo_model = '0;
    field_t       key_hi_model = '0;
    block_req_t   send_q[$];
    block_res_t   expect_q[$];
    int           blocks_outstanding = 0;
    int           mismatches = 0;
    int           cycles = 0;
    logic         in_taken = 1'b0;
    logic         out_taken = 1'b0;
    int           in_wait = 0;
    bit           in_armed = 1'b0;
    int           out_wait = 0;
    idle_mode_t   in_mode = IDLE_NONE;
    idle_mode_t   out_mode = IDLE_NONE;

    speck_block_cipher i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_valid       (drv_valid),
        .o_ready       (dut_ready),
        .i_func        (drv_func),
        .i_block_low   (drv_lo),
        .i_block_high  (drv_hi),
        .o_valid       (dut_valid),
        .i_ready       (rcv_ready),
        .o_result_low  (res_lo),
        .o_result_high (res_hi)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic t_word rotr(input t_word v, input int n);
        return (v >> n) | (v << (WORD_BITS - n));
    endfunction

    function automatic t_word rotl(input t_word v, input int n);
        return (v << n) | (v >> (WORD_BITS - n));
    endfunction

    // full key expansion per block; cheap enough at this item count
    function automatic block_res_t speck_model(input block_req_t req);
        t_word      rk [ROUNDS];
        t_word      k, l, x, y;
        block_res_t res;
        k = key_lo_model[WORD_BITS-1:0];
        l = key_hi_model[WORD_BITS-1:0];
        for (int r = 0; r < ROUNDS; r++) begin
            rk[r] = k;
            l = (rotr(l, 8) + k) ^ t_word'(r);
            k = rotl(k, 3) ^ l;
        end
        y = req.lo[WORD_BITS-1:0];
        x = req.hi[WORD_BITS-1:0];
        if (req.func == FUNC_ENC) begin
            for (int r = 0; r < ROUNDS; r++) begin
                x = (rotr(x, 8) + y) ^ rk[r];
                y = rotl(y, 3) ^ x;
            end
        end else begin
            for (int r = ROUNDS - 1; r >= 0; r--) begin
                y = rotr(y ^ x, 3);
                x = rotl((x ^ rk[r]) - y, 8);
            end
        end
        res.lo = field_t'(y);
        res.hi = field_t'(x);
        return res;
    endfunction

    function automatic field_t rand_word();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return field_t'(1) << $urandom_range(0, FIELD_W - 1);
            3: return ~(field_t'(1) << $urandom_range(0, FIELD_W - 1));
            default: return field_t'({$urandom, $urandom});
        endcase
    endfunction

    function automatic int draw_idle(input idle_mode_t mode);
        case (mode)
            IDLE_NONE: return 0;
            IDLE_FULL: return $urandom_range(0, IDLE_MAX);
            default: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, IDLE_MAX) : 0;
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
            $display("MISMATCH at %0t: %s", $time, what);
        end
    endtask

    task automatic queue_block(input logic func, input field_t lo, input field_t hi);
        block_req_t req;
        req.func = func;
        req.lo   = lo;
        req.hi   = hi;
        send_q.push_back(req);
        blocks_outstanding++;
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input field_t val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_KEY_LOW) begin
            key_lo_model = val;
        end else if (idx == REG_KEY_HIGH) begin
            key_hi_model = val;
        end
    endtask

    task automatic wait_drained();
        while (blocks_outstanding != 0) @(negedge clk);
    endtask

    task automatic run_random(input int count);
        block_req_t req;
        block_res_t ct;
        int         n;
        n = 0;
        while (n < count) begin
            req.func = 1'($urandom_range(0, 1));
            req.lo   = rand_word();
            req.hi   = rand_word();
            queue_block(req.func, req.lo, req.hi);
            n++;
            // round trip: feed the ciphertext back for decryption
            if (req.func == FUNC_ENC && $urandom_range(0, 3) == 0) begin
                ct = speck_model(req);
                queue_block(FUNC_DEC, ct.lo, ct.hi);
                n++;
            end
        end
    endtask

    // input driver
    always @(negedge clk) begin : drive_blocks
        logic       v;
        block_req_t req;
        v = drv_valid;
        if (in_taken) v = 1'b0;
        if (!rst_n) begin
            v = 1'b0;
        end else if (!v && send_q.size() != 0) begin
            if (!in_armed) begin
                in_wait  = draw_idle(in_mode);
                in_armed = 1'b1;
            end
            if (in_wait > 0) begin
                in_wait--;
            end else begin
                req = send_q.pop_front();
                drv_func <= req.func;
                drv_lo   <= req.lo;
                drv_hi   <= req.hi;
                v        = 1'b1;
                in_armed = 1'b0;
            end
        end
        drv_valid <= v;
    end

    // output back-pressure
    always @(negedge clk) begin : drive_ready
        if (out_taken) out_wait = draw_idle(out_mode);
        if (out_wait > 0) begin
            out_wait--;
            rcv_ready <= 1'b0;
        end else begin
            rcv_ready <= 1'b1;
        end
    end

    // monitor: predict on input transaction, check on output transaction
    always @(posedge clk) begin : watch_ports
        block_res_t want;
        block_req_t req;
        in_taken  <= rst_n && drv_valid && dut_ready;
        out_taken <= rst_n && dut_valid && rcv_ready;
        if (rst_n && drv_valid && dut_ready) begin
            req.func = drv_func;
            req.lo   = drv_lo;
            req.hi   = drv_hi;
            expect_q.push_back(speck_model(req));
        end
        if (rst_n && dut_valid && rcv_ready) begin
            if (expect_q.size() == 0) begin
                report_mismatch("result with no block outstanding");
            end else begin
                want = expect_q.pop_front();
                blocks_outstanding--;
                if (res_lo !== want.lo) begin
                    report_mismatch($sformatf("result_low got %h want %h", res_lo, want.lo));
                end
                if (res_hi !== want.hi) begin
                    report_mismatch($sformatf("result_high got %h want %h", res_hi, want.hi));
                end
            end
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        field_t key_a;
        field_t key_b;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // keys still at their reset value
        in_mode  = IDLE_SOME;
        out_mode = IDLE_SOME;
        queue_block(FUNC_ENC, '0, '0);
        queue_block(FUNC_DEC, '0, '0);
        queue_block(FUNC_ENC, '1, '1);
        queue_block(FUNC_DEC, '1, '1);
        wait_drained();

        write_reg(REG_KEY_LOW, VEC_KEY_LO);
        write_reg(REG_KEY_HIGH, VEC_KEY_HI);
        queue_block(FUNC_ENC, VEC_PT_LO, VEC_PT_HI);
        queue_block(FUNC_DEC, VEC_CT_LO, VEC_CT_HI);
        queue_block(FUNC_ENC, field_t'(1), '0);
        queue_block(FUNC_ENC, '0, field_t'(1));
        queue_block(FUNC_DEC, field_t'(1) << (FIELD_W - 1), field_t'(1) << (FIELD_W - 1));
        wait_drained();

        write_reg(REG_KEY_LOW, '1);
        write_reg(REG_KEY_HIGH, '1);
        queue_block(FUNC_ENC, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
        queue_block(FUNC_DEC, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
        queue_block(FUNC_ENC, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
        queue_block(FUNC_DEC, '0, '1);
        wait_drained();

        // unmapped index: keys must stay as they are
        write_reg(REG_SPARE, rand_word());
        queue_block(FUNC_ENC, '1, '0);
        queue_block(FUNC_DEC, 64'h0123456789abcdef, 64'hfedcba9876543210);
        wait_drained();

        for (int p = 0; p < 8; p++) begin
            case (p)
                0: begin
                    key_a    = '0;
                    key_b    = '1;
                    in_mode  = IDLE_NONE;
                    out_mode = IDLE_NONE;
                end
                1: begin
                    key_a    = '1;
                    key_b    = '0;
                    in_mode  = IDLE_FULL;
                    out_mode = IDLE_FULL;
                end
                default: begin
                    key_a    = field_t'({$urandom, $urandom});
                    key_b    = field_t'({$urandom, $urandom});
                    in_mode  = idle_mode_t'($urandom_range(0, 2));
                    out_mode = idle_mode_t'($urandom_range(0, 2));
                end
            endcase
            // one phase rekeys only the high word
            if (p != 5) write_reg(REG_KEY_LOW, key_a);
            write_reg(REG_KEY_HIGH, key_b);
            run_random(PHASE_ITEMS);
            wait_drained();
        end

        repeat (ROUNDS + 8) @(negedge clk);
        if (mismatches == 0 && expect_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
